FILE: rtl/spat_pkg.sv
// ----------------------------------------------------------------------------
// spat_pkg
// Shared types and constants for the slice share admission table.
// ----------------------------------------------------------------------------
package spat_pkg;

    // Table geometry
    localparam int MAX_SLICES = 16;
    localparam int SLOT_W     = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;

    // Field widths
    localparam int SHARE_W = 7;
    localparam int OPER_W  = 24;
    localparam int SVC_W   = 8;
    localparam int DIFF_W  = 24;
    localparam int IDENT_W = OPER_W + SVC_W + DIFF_W;
    localparam int TOTAL_W = 11;
    localparam int CAP_W   = 7;

    // Accumulator: every slot at full share plus the request
    localparam int SUM_RAW_W = $clog2(MAX_SLICES * (2**SHARE_W - 1) + 2**SHARE_W);
    localparam int SUM_W     = (SUM_RAW_W > TOTAL_W) ? SUM_RAW_W : TOTAL_W;
    localparam int TOTAL_MAX = 2**TOTAL_W - 1;

    // Differentiator stored when the request carries none
    localparam logic [DIFF_W-1:0] DIFF_ABSENT = 24'hFFFFFF;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CAP_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK    = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd100;

    // Result codes
    typedef enum logic [1:0] {
        VERDICT_ACCEPT     = 2'd0,
        VERDICT_OVER_CAP   = 2'd1,
        VERDICT_TABLE_FULL = 2'd2
    } verdict_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } spat_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
    } spat_status_t;

endpackage

FILE: rtl/spat_if.sv
// ----------------------------------------------------------------------------
// spat_if
// Request and result channels of the slice share admission table.
// ----------------------------------------------------------------------------
interface spat_req_if;
    import spat_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  min_valid;
    logic [SHARE_W-1:0]    min_share;
    logic                  max_valid;
    logic [SHARE_W-1:0]    max_share;
    logic                  ded_valid;
    logic [SHARE_W-1:0]    ded_share;
    logic                  id_valid;
    logic [OPER_W-1:0]     operator_code;
    logic [SVC_W-1:0]      service_type;
    logic                  diff_valid;
    logic [DIFF_W-1:0]     differentiator;

    modport source (
        output valid, min_valid, min_share, max_valid, max_share, ded_valid, ded_share,
               id_valid, operator_code, service_type, diff_valid, differentiator,
        input  ready
    );

    modport sink (
        input  valid, min_valid, min_share, max_valid, max_share, ded_valid, ded_share,
               id_valid, operator_code, service_type, diff_valid, differentiator,
        output ready
    );
endinterface

interface spat_rsp_if;
    import spat_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            verdict;
    logic [TOTAL_W-1:0]    total_share;

    modport source (
        output valid, verdict, total_share,
        input  ready
    );

    modport sink (
        input  valid, verdict, total_share,
        output ready
    );
endinterface

FILE: rtl/spat_ctrl.sv
// ----------------------------------------------------------------------------
// spat_ctrl
// Sequencer: take a request, sweep the table, commit and present the result.
// ----------------------------------------------------------------------------
module spat_ctrl
    import spat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  spat_status_t status,
    output spat_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        in_ready       = (state_reg == ST_IDLE);

        // result register drains independently of the sweep
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last table read lands in the accumulator
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/spat_dp.sv
// ----------------------------------------------------------------------------
// spat_dp
// Datapath: request latch, slot table, sweep accumulator, verdict and result.
// ----------------------------------------------------------------------------
module spat_dp
    import spat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request fields
    input  logic                  min_valid,
    input  logic [SHARE_W-1:0]    min_share,
    input  logic                  max_valid,
    input  logic [SHARE_W-1:0]    max_share,
    input  logic                  ded_valid,
    input  logic [SHARE_W-1:0]    ded_share,
    input  logic                  id_valid,
    input  logic [OPER_W-1:0]     operator_code,
    input  logic [SVC_W-1:0]      service_type,
    input  logic                  diff_valid,
    input  logic [DIFF_W-1:0]     differentiator,
    // control
    input  spat_cmd_t             cmd,
    output spat_status_t          status,
    // result fields
    output logic [1:0]            verdict,
    output logic [TOTAL_W-1:0]    total_share
);

    // Configuration registers
    logic [CAP_W-1:0]   cap_reg;
    logic               chk_reg;

    // Latched request
    logic [SHARE_W-1:0] req_share_reg;
    logic               id_valid_reg;
    logic [IDENT_W-1:0] ident_reg;
    logic [SHARE_W-1:0] req_share_next;
    logic [IDENT_W-1:0] ident_next;

    // Slot table
    logic [MAX_SLICES-1:0] used_reg;
    logic [IDENT_W-1:0]    ident_mem [MAX_SLICES];
    logic [SHARE_W-1:0]    share_mem [MAX_SLICES];

    // Sweep
    logic [SLOT_W-1:0]  scan_idx_reg;
    logic               rd_valid_reg;
    logic [SLOT_W-1:0]  rd_idx_reg;
    logic               used_rd_reg;
    logic [IDENT_W-1:0] ident_rd_reg;
    logic [SHARE_W-1:0] share_rd_reg;

    // Accumulator and slot search
    logic [SUM_W-1:0]   sum_reg;
    logic               match_found_reg;
    logic [SLOT_W-1:0]  match_idx_reg;
    logic               free_found_reg;
    logic [SLOT_W-1:0]  free_idx_reg;

    // Commit
    logic               over_cap;
    logic               store_en;
    logic               insert_en;
    logic [SLOT_W-1:0]  wr_idx;
    verdict_t           verdict_next;
    logic [TOTAL_W-1:0] total_next;

    // Result register
    verdict_t           verdict_reg;
    logic [TOTAL_W-1:0] total_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            chk_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPACITY: cap_reg <= cfg_data[CAP_W-1:0];
                CFG_CHECK:    chk_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Requested share: first present of min, max, dedicated
    always_comb
    begin
        if (min_valid)
        begin
            req_share_next = min_share;
        end
        else if (max_valid)
        begin
            req_share_next = max_share;
        end
        else if (ded_valid)
        begin
            req_share_next = ded_share;
        end
        else
        begin
            req_share_next = '0;
        end
        ident_next = {operator_code, service_type, diff_valid ? differentiator : DIFF_ABSENT};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_share_reg <= req_share_next;
            id_valid_reg  <= id_valid;
            ident_reg     <= ident_next;
        end
    end

    // Sweep address counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan)
            begin
                scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
            end
        end
    end

    assign status.scan_last = (scan_idx_reg == SLOT_W'(MAX_SLICES - 1));

    // Table read, one slot per cycle, registered
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            rd_idx_reg   <= scan_idx_reg;
            used_rd_reg  <= used_reg[scan_idx_reg];
            ident_rd_reg <= ident_mem[scan_idx_reg];
            share_rd_reg <= share_mem[scan_idx_reg];
        end
    end

    // Accumulate other slots, note matching and first free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg         <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
        end
        else if (cmd.load)
        begin
            sum_reg         <= SUM_W'(req_share_next);
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else if (rd_valid_reg)
        begin
            if (used_rd_reg)
            begin
                if (id_valid_reg && (ident_rd_reg == ident_reg))
                begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= rd_idx_reg;
                end
                else
                begin
                    sum_reg <= sum_reg + SUM_W'(share_rd_reg);
                end
            end
            else if (!free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
        end
    end

    // Verdict and table update
    always_comb
    begin
        over_cap  = (req_share_reg != '0) && chk_reg && (sum_reg > SUM_W'(cap_reg));
        store_en  = 1'b0;
        insert_en = 1'b0;
        wr_idx    = match_found_reg ? match_idx_reg : free_idx_reg;

        if (over_cap)
        begin
            verdict_next = VERDICT_OVER_CAP;
        end
        else if (id_valid_reg && !match_found_reg && !free_found_reg)
        begin
            verdict_next = VERDICT_TABLE_FULL;
        end
        else
        begin
            verdict_next = VERDICT_ACCEPT;
            store_en     = cmd.commit && id_valid_reg;
            insert_en    = cmd.commit && id_valid_reg && !match_found_reg;
        end

        if (sum_reg > SUM_W'(TOTAL_MAX))
        begin
            total_next = TOTAL_W'(TOTAL_MAX);
        end
        else
        begin
            total_next = sum_reg[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            share_mem[wr_idx] <= req_share_reg;
        end
        if (insert_en)
        begin
            ident_mem[wr_idx] <= ident_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (insert_en)
        begin
            used_reg[wr_idx] <= 1'b1;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            verdict_reg <= verdict_next;
            total_reg   <= total_next;
        end
    end

    assign verdict     = verdict_reg;
    assign total_share = total_reg;

endmodule

FILE: rtl/slice_prb_admission_table_top.sv
// A new request is taken only once the previous one has been swept and committed; the table sweep
//   reads one slot per cycle from the single table read port.
// A finished result waits in its output register while the next request is taken.
// Reset: asynchronous, active low; clears all slot used bits, capacity to 100,
//   check enabled. No clearing pass is needed.
// ----------------------------------------------------------------------------
// slice_prb_admission_table_top
// Admission control of slice resource-block shares against a capacity limit.
// ----------------------------------------------------------------------------
module slice_prb_admission_table_top
    import spat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    spat_req_if.sink              req,
    spat_rsp_if.source            rsp
);

    spat_cmd_t    cmd;
    spat_status_t status;

    // Sequencer
    spat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Table and arithmetic
    spat_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .min_valid      (req.min_valid),
        .min_share      (req.min_share),
        .max_valid      (req.max_valid),
        .max_share      (req.max_share),
        .ded_valid      (req.ded_valid),
        .ded_share      (req.ded_share),
        .id_valid       (req.id_valid),
        .operator_code  (req.operator_code),
        .service_type   (req.service_type),
        .diff_valid     (req.diff_valid),
        .differentiator (req.differentiator),
        .cmd            (cmd),
        .status         (status),
        .verdict        (rsp.verdict),
        .total_share    (rsp.total_share)
    );

endmodule

FILE: rtl/spat_checker.sv
// ----------------------------------------------------------------------------
// spat_checker
// Port-level checks on the slice share admission table.
// ----------------------------------------------------------------------------
module spat_checker
    import spat_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         verdict,
    input logic [TOTAL_W-1:0] total_share
);

    // One request at a time: taken request closes the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while another is in progress");

    // Result never appears in the cycle right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result too early after request");

    // Only defined verdict codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == VERDICT_ACCEPT || verdict == VERDICT_OVER_CAP ||
                       verdict == VERDICT_TABLE_FULL))
        else $error("undefined verdict code");

    // Over-capacity means a non-zero total
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && verdict == VERDICT_OVER_CAP) |-> (total_share != '0))
        else $error("over-capacity verdict with zero total");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(verdict) && $stable(total_share)))
        else $error("stalled result changed");

endmodule

bind slice_prb_admission_table_top spat_checker u_spat_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .verdict     (rsp.verdict),
    .total_share (rsp.total_share)
);
